[hw/rtl/tlad_pkg.sv]
// Shared constants, register codes and types for the tank level alarm block.
`default_nettype none
package tlad_pkg;

	localparam int LEVEL_BITS = 12;
	localparam int TIME_BITS  = 32;
	localparam int CFG_BITS   = 12;
	localparam int IDX_BITS   = 3;
	localparam int MS_PER_S   = 1000;
	// seconds register times 1000 fits here
	localparam int MS_BITS    = 22;
	localparam int CMP_BITS   = (TIME_BITS > MS_BITS) ? TIME_BITS : MS_BITS;

	typedef enum logic [IDX_BITS-1:0] {
		REG_LEVEL_HIGH_BIG   = 3'd0,
		REG_LEVEL_HIGH_SMALL = 3'd1,
		REG_DELAY_BIG_S      = 3'd2,
		REG_DELAY_SMALL_S    = 3'd3,
		REG_REPEAT_BIG_S     = 3'd4,
		REG_REPEAT_SMALL_S   = 3'd5
	} reg_idx_t;

	localparam logic [LEVEL_BITS-1:0] LEVEL_HIGH_RST = {LEVEL_BITS{1'b1}};
	localparam logic [MS_BITS-1:0]    DELAY_MS_RST   = MS_BITS'(10 * MS_PER_S);
	localparam logic [MS_BITS-1:0]    REPEAT_MS_RST  = MS_BITS'(60 * MS_PER_S);

	typedef struct packed {
		logic [LEVEL_BITS-1:0] thresh;
		logic [MS_BITS-1:0]    delay_ms;
		logic [MS_BITS-1:0]    repeat_ms;
	} tank_cfg_t;

	typedef struct packed {
		logic alarm;
		logic ack_state;
	} tank_res_t;

endpackage
`default_nettype wire

[hw/rtl/tlad_cfg.sv]
// Configuration registers; times are held converted to milliseconds.
`default_nettype none
module tlad_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tlad_pkg::IDX_BITS-1:0] cfg_idx,
	input  wire logic [tlad_pkg::CFG_BITS-1:0] cfg_wdata,
	output tlad_pkg::tank_cfg_t                cfg_big,
	output tlad_pkg::tank_cfg_t                cfg_small
);

	logic [tlad_pkg::LEVEL_BITS-1:0] level_high_big_q, level_high_small_q;
	logic [tlad_pkg::MS_BITS-1:0]    delay_big_q, delay_small_q;
	logic [tlad_pkg::MS_BITS-1:0]    repeat_big_q, repeat_small_q;
	logic [tlad_pkg::MS_BITS-1:0]    wdata_ms;
	logic [tlad_pkg::LEVEL_BITS-1:0] wdata_lvl;

	assign wdata_ms  = tlad_pkg::MS_BITS'(cfg_wdata) * tlad_pkg::MS_BITS'(tlad_pkg::MS_PER_S);
	assign wdata_lvl = tlad_pkg::LEVEL_BITS'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_high_big_q   <= tlad_pkg::LEVEL_HIGH_RST;
			level_high_small_q <= tlad_pkg::LEVEL_HIGH_RST;
			delay_big_q        <= tlad_pkg::DELAY_MS_RST;
			delay_small_q      <= tlad_pkg::DELAY_MS_RST;
			repeat_big_q       <= tlad_pkg::REPEAT_MS_RST;
			repeat_small_q     <= tlad_pkg::REPEAT_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tlad_pkg::REG_LEVEL_HIGH_BIG:   level_high_big_q   <= wdata_lvl;
				tlad_pkg::REG_LEVEL_HIGH_SMALL: level_high_small_q <= wdata_lvl;
				tlad_pkg::REG_DELAY_BIG_S:      delay_big_q        <= wdata_ms;
				tlad_pkg::REG_DELAY_SMALL_S:    delay_small_q      <= wdata_ms;
				tlad_pkg::REG_REPEAT_BIG_S:     repeat_big_q       <= wdata_ms;
				tlad_pkg::REG_REPEAT_SMALL_S:   repeat_small_q     <= wdata_ms;
				default: ;
			endcase
		end
	end

	assign cfg_big   = '{thresh: level_high_big_q, delay_ms: delay_big_q,
		repeat_ms: repeat_big_q};
	assign cfg_small = '{thresh: level_high_small_q, delay_ms: delay_small_q,
		repeat_ms: repeat_small_q};

endmodule
`default_nettype wire

[hw/rtl/tlad_tank.sv]
// Per-tank alarm state: on-delay, acknowledge latch and repeat timing.
`default_nettype none
module tlad_tank (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step,
	input  wire logic [tlad_pkg::TIME_BITS-1:0]  now,
	input  wire logic [tlad_pkg::LEVEL_BITS-1:0] level,
	input  wire logic                            ack_pulse,
	input  wire tlad_pkg::tank_cfg_t             cfg,
	output tlad_pkg::tank_res_t                  res
);

	logic [tlad_pkg::TIME_BITS-1:0] timer_start_q, timer_start_d;
	logic delay_armed_q, delay_armed_d;
	logic repeat_armed_q, repeat_armed_d;
	logic raised_once_q, raised_once_d;
	logic ack_latch_q, ack_latch_d;
	logic ack_set, armed, alarm;
	logic [tlad_pkg::TIME_BITS-1:0] elapsed;
	logic [tlad_pkg::CMP_BITS-1:0]  elapsed_x, limit_x;

	assign ack_set = ack_latch_q | ack_pulse;
	assign armed   = ack_set ? repeat_armed_q : delay_armed_q;
	// an unarmed timer starts on this sample, so nothing has elapsed yet
	assign elapsed   = armed ? (now - timer_start_q) : '0;
	assign elapsed_x = tlad_pkg::CMP_BITS'(elapsed);
	assign limit_x   = ack_set ? tlad_pkg::CMP_BITS'(cfg.repeat_ms)
		: tlad_pkg::CMP_BITS'(cfg.delay_ms);

	always_comb begin
		timer_start_d  = timer_start_q;
		delay_armed_d  = delay_armed_q;
		repeat_armed_d = repeat_armed_q;
		raised_once_d  = raised_once_q;
		ack_latch_d    = ack_set;
		alarm          = 1'b0;
		if (level > cfg.thresh) begin
			if (!armed) begin
				timer_start_d = now;
			end
			if (!ack_set) begin
				delay_armed_d = 1'b1;
				if (elapsed_x >= limit_x && !raised_once_q) begin
					raised_once_d  = 1'b1;
					delay_armed_d  = 1'b0;
					repeat_armed_d = 1'b0;
					alarm          = 1'b1;
				end
			end else begin
				repeat_armed_d = 1'b1;
				if (elapsed_x >= limit_x) begin
					repeat_armed_d = 1'b0;
					ack_latch_d    = 1'b0;
					alarm          = 1'b1;
				end
			end
		end else begin
			ack_latch_d   = 1'b0;
			delay_armed_d = 1'b0;
			raised_once_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_start_q  <= '0;
			delay_armed_q  <= 1'b0;
			repeat_armed_q <= 1'b0;
			raised_once_q  <= 1'b0;
			ack_latch_q    <= 1'b0;
		end else if (step) begin
			timer_start_q  <= timer_start_d;
			delay_armed_q  <= delay_armed_d;
			repeat_armed_q <= repeat_armed_d;
			raised_once_q  <= raised_once_d;
			ack_latch_q    <= ack_latch_d;
		end
	end

	assign res = '{alarm: alarm, ack_state: ack_latch_d};

endmodule
`default_nettype wire

[hw/rtl/tank_level_alarm_delay_repeat.sv]
// Top level: tank level alarm with on-delay, acknowledge and repeat.
// Usage:
//   Input channel in_valid/in_stall carries one acquisition sample per word:
//   timestamp, two levels, two active-low overflow sensors, two ack pulses.
//   Output channel out_valid/out_stall carries one result word per sample:
//   forced-off flags, alarms and acknowledge latch states.
//   A word is taken at a clock edge with valid high and stall low.
//   A sample taken in is held in the input register, then its result in
//   the result register.
//   Throughput: one sample per cycle while the receiver does not stall;
//   the per-tank state update (one timestamp subtract and compare) closes
//   in the cycle between the two registers.
//   Receiver stall: the result register holds; the input register keeps
//   one more sample, after which in_stall rises until the result is taken.
//   Reset: all alarm state clears, thresholds go to 4095, delays to 10 s,
//   repeat times to 60 s. Registers must be written through cfg_we/cfg_idx/
//   cfg_wdata while no sample is in flight; the block does not enforce it.
`default_nettype none
module tank_level_alarm_delay_repeat (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tlad_pkg::IDX_BITS-1:0]   cfg_idx,
	input  wire logic [tlad_pkg::CFG_BITS-1:0]   cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [31:0]                     now_ms,
	input  wire logic [tlad_pkg::LEVEL_BITS-1:0] level_big,
	input  wire logic [tlad_pkg::LEVEL_BITS-1:0] level_small,
	input  wire logic                            overflow_big_n,
	input  wire logic                            overflow_small_n,
	input  wire logic                            ack_big_pulse,
	input  wire logic                            ack_small_pulse,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 pump_off,
	output logic                                 hot_water_off,
	output logic                                 cold_water_off,
	output logic                                 alarm_big,
	output logic                                 alarm_small,
	output logic                                 ack_big_state,
	output logic                                 ack_small_state
);

	tlad_pkg::tank_cfg_t cfg_big, cfg_small;
	tlad_pkg::tank_res_t res_big, res_small;

	logic                            valid_s1;
	logic [tlad_pkg::TIME_BITS-1:0]  now_s1;
	logic [tlad_pkg::LEVEL_BITS-1:0] level_big_s1, level_small_s1;
	logic ovf_big_s1, ovf_small_s1, ack_big_s1, ack_small_s1;
	logic valid_s2;
	logic pump_off_s2, valves_off_s2, alarm_big_s2, alarm_small_s2;
	logic ack_big_s2, ack_small_s2;
	logic adv, in_take;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	tlad_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg_big   (cfg_big),
		.cfg_small (cfg_small)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			now_s1         <= tlad_pkg::TIME_BITS'(now_ms);
			level_big_s1   <= level_big;
			level_small_s1 <= level_small;
			ovf_big_s1     <= !overflow_big_n;
			ovf_small_s1   <= !overflow_small_n;
			ack_big_s1     <= ack_big_pulse;
			ack_small_s1   <= ack_small_pulse;
		end
	end

	tlad_tank u_tank_big (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && adv),
		.now       (now_s1),
		.level     (level_big_s1),
		.ack_pulse (ack_big_s1),
		.cfg       (cfg_big),
		.res       (res_big)
	);

	tlad_tank u_tank_small (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && adv),
		.now       (now_s1),
		.level     (level_small_s1),
		.ack_pulse (ack_small_s1),
		.cfg       (cfg_small),
		.res       (res_small)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			pump_off_s2    <= ovf_big_s1 || ovf_small_s1;
			valves_off_s2  <= ovf_small_s1;
			alarm_big_s2   <= res_big.alarm;
			alarm_small_s2 <= res_small.alarm;
			ack_big_s2     <= res_big.ack_state;
			ack_small_s2   <= res_small.ack_state;
		end
	end

	assign out_valid       = valid_s2;
	assign pump_off        = pump_off_s2;
	assign hot_water_off   = valves_off_s2;
	assign cold_water_off  = valves_off_s2;
	assign alarm_big       = alarm_big_s2;
	assign alarm_small     = alarm_small_s2;
	assign ack_big_state   = ack_big_s2;
	assign ack_small_state = ack_small_s2;

	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> !in_stall)
		else $error("input stalled while result register empty");

	a_s1_moves_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv |=> valid_s2)
		else $error("advanced word missing from result register");

	a_alarm_clears_ack: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && alarm_big_s2 |-> !ack_big_s2)
		else $error("big tank alarm raised with acknowledge still set");

	a_alarm_clears_ack_small: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && alarm_small_s2 |-> !ack_small_s2)
		else $error("small tank alarm raised with acknowledge still set");

	a_valves_imply_pump: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && valves_off_s2 |-> pump_off_s2)
		else $error("valves forced off without pump forced off");

endmodule
`default_nettype wire

[tb/sv/tank_level_alarm_delay_repeat_tb.sv]
// Testbench for the tank level alarm block: directed table and random samples against a local model.
module tank_level_alarm_delay_repeat_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tlad_pkg::*;

	localparam logic [IDX_BITS-1:0] REG_SPARE = 3'd6;
	localparam int PHASES      = 12;
	localparam int PHASE_WORDS = 112;
	localparam int HOLD_CYCLES = 60;
	localparam int DIR_ROWS    = 25;
	localparam int DRAIN_LIMIT = 2000;

	typedef struct packed {
		logic [31:0]           now;
		logic [LEVEL_BITS-1:0] lvl_big;
		logic [LEVEL_BITS-1:0] lvl_small;
		logic                  ovf_big_n;
		logic                  ovf_small_n;
		logic                  ack_big;
		logic                  ack_small;
	} sample_t;

	typedef struct packed {
		logic pump_off;
		logic hot_off;
		logic cold_off;
		logic alarm_big;
		logic alarm_small;
		logic ack_big;
		logic ack_small;
	} out_word_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] timer_t0;
		logic                 delay_armed;
		logic                 repeat_armed;
		logic                 raised;
		logic                 acked;
	} tank_track_t;

	typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [IDX_BITS-1:0] idx;
		logic [CFG_BITS-1:0] val;
		sample_t             smp;
		logic                typed;
		out_word_t           want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [IDX_BITS-1:0]   cfg_idx = '0;
	logic [CFG_BITS-1:0]   cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [31:0]           now_ms = '0;
	logic [LEVEL_BITS-1:0] level_big = '0;
	logic [LEVEL_BITS-1:0] level_small = '0;
	logic                  overflow_big_n = 1'b1;
	logic                  overflow_small_n = 1'b1;
	logic                  ack_big_pulse = 1'b0;
	logic                  ack_small_pulse = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  pump_off;
	logic                  hot_water_off;
	logic                  cold_water_off;
	logic                  alarm_big;
	logic                  alarm_small;
	logic                  ack_big_state;
	logic                  ack_small_state;

	logic [LEVEL_BITS-1:0] thr_big = '1;
	logic [LEVEL_BITS-1:0] thr_small = '1;
	logic [CFG_BITS-1:0]   dly_big = 12'd10;
	logic [CFG_BITS-1:0]   dly_small = 12'd10;
	logic [CFG_BITS-1:0]   rep_big = 12'd60;
	logic [CFG_BITS-1:0]   rep_small = 12'd60;
	tank_track_t           tank_big_st = '0;
	tank_track_t           tank_small_st = '0;

	out_word_t outputs_due [$];
	plan_row_t plan [DIR_ROWS];

	int  mismatches = 0;
	int  words_checked = 0;
	int  alarms_seen = 0;
	int  samples_sent = 0;
	int  reg_writes = 0;
	int  gap_pct = 0;
	int  stall_pct = 0;
	bit  quiet = 1'b0;
	bit  hold_req = 1'b0;

	tank_level_alarm_delay_repeat dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.now_ms           (now_ms),
		.level_big        (level_big),
		.level_small      (level_small),
		.overflow_big_n   (overflow_big_n),
		.overflow_small_n (overflow_small_n),
		.ack_big_pulse    (ack_big_pulse),
		.ack_small_pulse  (ack_small_pulse),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.pump_off         (pump_off),
		.hot_water_off    (hot_water_off),
		.cold_water_off   (cold_water_off),
		.alarm_big        (alarm_big),
		.alarm_small      (alarm_small),
		.ack_big_state    (ack_big_state),
		.ack_small_state  (ack_small_state)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("tank_level_alarm_delay_repeat_tb: errors");
		$finish;
	end

	function automatic plan_row_t sample_row(input logic [31:0] now,
			input logic [LEVEL_BITS-1:0] lb, input logic [LEVEL_BITS-1:0] ls,
			input logic [1:0] ovf_n, input logic [1:0] ack);
		plan_row_t r;
		r = '0;
		r.kind = ROW_SAMPLE;
		r.smp = '{now, lb, ls, ovf_n[1], ovf_n[0], ack[1], ack[0]};
		return r;
	endfunction

	function automatic plan_row_t typed_row(input logic [31:0] now,
			input logic [LEVEL_BITS-1:0] lb, input logic [LEVEL_BITS-1:0] ls,
			input logic [1:0] ovf_n, input logic [1:0] ack, input out_word_t want);
		plan_row_t r;
		r = sample_row(now, lb, ls, ovf_n, ack);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic plan_row_t reg_row(input logic [IDX_BITS-1:0] idx,
			input logic [CFG_BITS-1:0] val);
		plan_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic logic [LEVEL_BITS-1:0] pick_level(input logic above,
			input logic [LEVEL_BITS-1:0] thr);
		if ($urandom_range(0, 9) == 0)
			return LEVEL_BITS'($urandom_range(0, 4095));
		if (above && thr != '1)
			return LEVEL_BITS'($urandom_range(thr + 1, 4095));
		if (above)
			return '1;
		return LEVEL_BITS'($urandom_range(0, thr));
	endfunction

	function automatic logic [CFG_BITS-1:0] pick_seconds();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 12'd3600;
			2: return CFG_BITS'($urandom_range(0, 3600));
			default: return CFG_BITS'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic void check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic step_tank(inout tank_track_t st, input logic [TIME_BITS-1:0] now,
			input logic [LEVEL_BITS-1:0] lvl, input logic [LEVEL_BITS-1:0] thr,
			input logic [CFG_BITS-1:0] dly_s, input logic [CFG_BITS-1:0] rep_s,
			input logic ack_in, output logic alarm);
		logic [TIME_BITS-1:0] elapsed;
		alarm = 1'b0;
		if (ack_in)
			st.acked = 1'b1;
		if (lvl > thr) begin
			if (!st.acked) begin
				if (!st.delay_armed) begin
					st.timer_t0 = now;
					st.delay_armed = 1'b1;
				end
				elapsed = now - st.timer_t0;
				if (elapsed >= dly_s * 32'd1000 && !st.raised) begin
					st.raised = 1'b1;
					st.delay_armed = 1'b0;
					st.repeat_armed = 1'b0;
					alarm = 1'b1;
				end
			end else begin
				if (!st.repeat_armed) begin
					st.timer_t0 = now;
					st.repeat_armed = 1'b1;
				end
				elapsed = now - st.timer_t0;
				if (elapsed >= rep_s * 32'd1000) begin
					st.repeat_armed = 1'b0;
					st.acked = 1'b0;
					alarm = 1'b1;
				end
			end
		end else begin
			st.acked = 1'b0;
			st.delay_armed = 1'b0;
			st.raised = 1'b0;
		end
	endtask

	task automatic run_alarm_logic(input sample_t s, output out_word_t w);
		logic a_big;
		logic a_small;
		step_tank(tank_big_st, s.now, s.lvl_big, thr_big, dly_big, rep_big, s.ack_big, a_big);
		step_tank(tank_small_st, s.now, s.lvl_small, thr_small, dly_small, rep_small,
			s.ack_small, a_small);
		w.pump_off    = !s.ovf_big_n || !s.ovf_small_n;
		w.hot_off     = !s.ovf_small_n;
		w.cold_off    = !s.ovf_small_n;
		w.alarm_big   = a_big;
		w.alarm_small = a_small;
		w.ack_big     = tank_big_st.acked;
		w.ack_small   = tank_small_st.acked;
	endtask

	task automatic offer_sample(input sample_t s, input logic typed, input out_word_t want);
		out_word_t pred;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		now_ms           <= s.now;
		level_big        <= s.lvl_big;
		level_small      <= s.lvl_small;
		overflow_big_n   <= s.ovf_big_n;
		overflow_small_n <= s.ovf_small_n;
		ack_big_pulse    <= s.ack_big;
		ack_small_pulse  <= s.ack_small;
		in_valid         <= 1'b1;
		do @(posedge clk); while (in_stall);
		run_alarm_logic(s, pred);
		outputs_due.push_back(typed ? want : pred);
		samples_sent++;
	endtask

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_LEVEL_HIGH_BIG:   thr_big = val;
			REG_LEVEL_HIGH_SMALL: thr_small = val;
			REG_DELAY_BIG_S:      dly_big = val;
			REG_DELAY_SMALL_S:    dly_small = val;
			REG_REPEAT_BIG_S:     rep_big = val;
			REG_REPEAT_SMALL_S:   rep_small = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	// drop valid, wait for the pipe to empty
	task automatic settle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (outputs_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	// receiver: random stall bursts plus one long hold on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		out_word_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (outputs_due.size() == 0) begin
					$error("result word with no sample pending");
					mismatches++;
				end else begin
					want = outputs_due.pop_front();
					check_field("pump_off", want.pump_off, pump_off);
					check_field("hot_water_off", want.hot_off, hot_water_off);
					check_field("cold_water_off", want.cold_off, cold_water_off);
					check_field("alarm_big", want.alarm_big, alarm_big);
					check_field("alarm_small", want.alarm_small, alarm_small);
					check_field("ack_big_state", want.ack_big, ack_big_state);
					check_field("ack_small_state", want.ack_small, ack_small_state);
					words_checked++;
					if (alarm_big || alarm_small)
						alarms_seen++;
				end
			end
		end
	end

	initial begin
		sample_t             s;
		logic                high_big;
		logic                high_small;
		int unsigned         largest;
		int unsigned         step_max;
		logic [CFG_BITS-1:0] pv [6];

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// typed rows: reset thresholds sit at full scale, so no level is ever high
		plan = '{
			typed_row(32'h0000_0000, 12'd0, 12'd0, 2'b11, 2'b00, 7'b0000000),
			typed_row(32'hFFFF_FFFF, 12'hFFF, 12'hFFF, 2'b01, 2'b00, 7'b1000000),
			typed_row(32'h8000_0000, 12'hFFF, 12'd0, 2'b10, 2'b00, 7'b1110000),
			typed_row(32'h0000_0001, 12'd0, 12'hFFF, 2'b00, 2'b00, 7'b1110000),
			typed_row(32'h7FFF_FFFF, 12'hFFF, 12'hFFF, 2'b11, 2'b11, 7'b0000000),
			reg_row(REG_LEVEL_HIGH_BIG, 12'd100),
			reg_row(REG_LEVEL_HIGH_SMALL, 12'd200),
			reg_row(REG_DELAY_BIG_S, 12'd0),
			reg_row(REG_DELAY_SMALL_S, 12'd2),
			reg_row(REG_REPEAT_BIG_S, 12'd0),
			reg_row(REG_REPEAT_SMALL_S, 12'd1),
			reg_row(REG_SPARE, 12'hFFF),
			sample_row(32'd1000, 12'd101, 12'd201, 2'b11, 2'b00),
			sample_row(32'd2000, 12'd101, 12'd201, 2'b11, 2'b00),
			sample_row(32'd3000, 12'd101, 12'd201, 2'b11, 2'b00),
			sample_row(32'd3500, 12'd101, 12'd201, 2'b11, 2'b10),
			sample_row(32'd4000, 12'd101, 12'd201, 2'b11, 2'b01),
			sample_row(32'd4999, 12'd101, 12'd201, 2'b11, 2'b00),
			sample_row(32'd5000, 12'd101, 12'd201, 2'b11, 2'b00),
			sample_row(32'd5100, 12'd100, 12'hFFF, 2'b11, 2'b00),
			sample_row(32'd5200, 12'hFFF, 12'hFFF, 2'b10, 2'b00),
			sample_row(32'hFFFF_E000, 12'd0, 12'd0, 2'b11, 2'b00),
			sample_row(32'hFFFF_F000, 12'd0, 12'd300, 2'b11, 2'b00),
			sample_row(32'h0000_0400, 12'd0, 12'd300, 2'b11, 2'b00),
			sample_row(32'h0000_0500, 12'd0, 12'd0, 2'b01, 2'b11)
		};

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				settle();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				offer_sample(plan[i].smp, plan[i].typed, plan[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			for (int r = 0; r < 6; r++)
				pv[r] = (r < 2) ? CFG_BITS'($urandom_range(0, 4095)) : pick_seconds();
			case (p)
				0: pv = '{default: '0};
				1: pv = '{12'd4095, 12'd4095, 12'd3600, 12'd3600, 12'd3600, 12'd3600};
				2: begin
					pv[REG_DELAY_BIG_S]    = 12'd3600;
					pv[REG_DELAY_SMALL_S]  = 12'd3600;
					pv[REG_REPEAT_BIG_S]   = 12'd0;
					pv[REG_REPEAT_SMALL_S] = 12'd0;
				end
				3: begin
					pv[REG_DELAY_BIG_S]    = 12'd0;
					pv[REG_DELAY_SMALL_S]  = 12'd0;
					pv[REG_REPEAT_BIG_S]   = 12'd3600;
					pv[REG_REPEAT_SMALL_S] = 12'd3600;
				end
				default: ;
			endcase
			settle();
			for (int r = 0; r < 6; r++)
				write_reg(IDX_BITS'(r), pv[r]);

			quiet = (p >= PHASES - 2);
			gap_pct = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
			stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);

			// time steps scaled so the longest timer elapses within a few samples
			largest = 0;
			for (int r = 2; r < 6; r++)
				if (pv[r] > largest)
					largest = pv[r];
			step_max = largest * 1000 / 4 + 400;

			s = '0;
			s.now = $urandom;
			high_big = 1'($urandom_range(0, 1));
			high_small = 1'($urandom_range(0, 1));
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if ((p == 3 || p == 8) && k == 30)
					hold_req = 1'b1;
				if ($urandom_range(0, 24) == 0)
					s.now = $urandom;
				else
					s.now += $urandom_range(0, step_max);
				if ($urandom_range(0, 7) == 0)
					high_big = ~high_big;
				if ($urandom_range(0, 7) == 0)
					high_small = ~high_small;
				s.lvl_big     = pick_level(high_big, thr_big);
				s.lvl_small   = pick_level(high_small, thr_small);
				s.ovf_big_n   = ($urandom_range(0, 4) != 0);
				s.ovf_small_n = ($urandom_range(0, 4) != 0);
				s.ack_big     = ($urandom_range(0, 5) == 0);
				s.ack_small   = ($urandom_range(0, 5) == 0);
				offer_sample(s, 1'b0, '0);
			end
		end

		settle();
		repeat (6) @(posedge clk);
		if (outputs_due.size() != 0) begin
			$error("%0d result words never arrived", outputs_due.size());
			mismatches++;
		end
		$display("%0d samples sent, %0d result words checked, %0d carried an alarm",
			samples_sent, words_checked, alarms_seen);
		$display("%0d register writes across %0d threshold and timer settings",
			reg_writes, PHASES + 1);
		if (mismatches == 0) begin
			$display("tank_level_alarm_delay_repeat_tb: clean");
		end else begin
			$display("tank_level_alarm_delay_repeat_tb: errors");
		end
		$finish;
	end

endmodule
